@@ rtl/core/fgvsl_pkg.sv @@
`default_nettype none

package fgvsl_pkg;

	// voltage format: signed fixed point
	localparam int FRACTION_BITS = 12;
	localparam int VOLT_W        = 24;
	// internal width holds p + 2*|p - t| + 2 without overflow
	localparam int CALC_W        = VOLT_W + 4;

	typedef logic signed [VOLT_W-1:0] volt_t;
	typedef logic signed [CALC_W-1:0] calc_t;

	typedef struct packed {
		volt_t thr_v;
		volt_t prev_v;
		volt_t new_v;
	} volt_set_t;

	localparam calc_t FX_ONE        = calc_t'(64'sd1 <<< FRACTION_BITS);
	localparam calc_t FX_HALF       = calc_t'(64'sd1 <<< (FRACTION_BITS - 1));
	localparam calc_t FX_TWO        = calc_t'(64'sd2 <<< FRACTION_BITS);
	localparam calc_t FX_FOUR       = calc_t'(64'sd4 <<< FRACTION_BITS);
	localparam calc_t FX_THREE_HALF = calc_t'(64'sd7 <<< (FRACTION_BITS - 1));

	localparam calc_t VOLT_MAX = calc_t'((64'sd1 <<< (VOLT_W - 1)) - 64'sd1);
	localparam calc_t VOLT_MIN = calc_t'(-(64'sd1 <<< (VOLT_W - 1)));

endpackage

`default_nettype wire

@@ rtl/core/fgvsl_limit.sv @@
`default_nettype none

module fgvsl_limit (
	input  fgvsl_pkg::volt_set_t in_set,
	output fgvsl_pkg::volt_t     result
);

	fgvsl_pkg::calc_t v, p, t;
	fgvsl_pkg::calc_t gap, mag, hi, lo, tox, d, nd;
	fgvsl_pkg::calc_t t_plus_two, t_minus_half, t_plus_four, t_plus_half;
	fgvsl_pkg::calc_t r, r_sat;

	assign v = fgvsl_pkg::calc_t'(in_set.new_v);
	assign p = fgvsl_pkg::calc_t'(in_set.prev_v);
	assign t = fgvsl_pkg::calc_t'(in_set.thr_v);

	assign gap = p - t;
	assign mag = gap[fgvsl_pkg::CALC_W-1] ? -gap : gap;
	assign hi  = (mag <<< 1) + fgvsl_pkg::FX_TWO;
	assign lo  = mag + fgvsl_pkg::FX_ONE;
	assign tox = t + fgvsl_pkg::FX_THREE_HALF;
	assign d   = v - p;
	assign nd  = p - v;

	assign t_plus_two   = t + fgvsl_pkg::FX_TWO;
	assign t_minus_half = t - fgvsl_pkg::FX_HALF;
	assign t_plus_four  = t + fgvsl_pkg::FX_FOUR;
	assign t_plus_half  = t + fgvsl_pkg::FX_HALF;

	always_comb begin
		priority if (p >= tox) begin
			// on region
			if (d <= 0) begin
				if (v >= tox) r = (nd > lo) ? p - lo : v;
				else          r = (v > t_plus_two) ? v : t_plus_two;
			end else begin
				r = (d >= hi) ? p + hi : v;
			end
		end else if (p >= t) begin
			// middle region
			if (d <= 0) r = (v > t_minus_half) ? v : t_minus_half;
			else        r = (v < t_plus_four) ? v : t_plus_four;
		end else begin
			// off region
			if (d <= 0)                r = (nd > hi) ? p - hi : v;
			else if (v <= t_plus_half) r = (d > lo) ? p + lo : v;
			else                       r = t_plus_half;
		end
	end

	always_comb begin
		priority if (r > fgvsl_pkg::VOLT_MAX) r_sat = fgvsl_pkg::VOLT_MAX;
		else if (r < fgvsl_pkg::VOLT_MIN)     r_sat = fgvsl_pkg::VOLT_MIN;
		else                                  r_sat = r;
	end

	assign result = r_sat[fgvsl_pkg::VOLT_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/fet_gate_voltage_step_limiter_unit.sv @@
`default_nettype none

// gate voltage step limiter for a fet model, fetlim style: each input transfer carries
// the proposed, previous and threshold gate voltages (signed, 12 fraction bits) and
// gives exactly one limited voltage, saturated to 24 bits. one item is taken every
// clock cycle while downstream takes results; each item passes the input register and
// then the result register, with the limiter logic between them. s_axis_tready follows
// m_axis_tready combinationally, so a full pipeline keeps streaming as long as the
// downstream side takes results, and an empty stage always accepts

module fet_gate_voltage_step_limiter_unit (
	input  wire         clk,
	input  wire         arst_n,
	// input stream
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [71:0] s_axis_tdata,   // new_voltage [23:0], previous_voltage [47:24],
	                                    // threshold_voltage [71:48]
	// result stream
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata    // limited_voltage [23:0]
);

	// stage 1: registered input triple
	fgvsl_pkg::volt_set_t in_s1;
	logic                 valid_s1;
	// stage 2: registered result, drives the output port
	fgvsl_pkg::volt_t     result_s2;
	logic                 valid_s2;

	fgvsl_pkg::volt_t     result_c;
	logic                 load_s1, load_s2;

	// result register is free when empty or its transfer completes now
	assign load_s2       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || load_s2;
	assign load_s1       = s_axis_tvalid && s_axis_tready;

	// unpack the input transfer, lowest field first (new_v sits in the low bits)
	fgvsl_pkg::volt_set_t in_c;
	assign in_c = fgvsl_pkg::volt_set_t'(s_axis_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= 1'b1;
			else if (load_s2)
				valid_s1 <= 1'b0;

			if (load_s2)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (load_s1)
			in_s1 <= in_c;
		if (load_s2)
			result_s2 <= result_c;
	end

	// region and direction decision plus saturation
	fgvsl_limit u_limit (
		.in_set (in_s1),
		.result (result_c)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	// an empty input stage must never stall the upstream side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// an accepted transfer lands in the input stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		load_s1 |=> valid_s1)
		else $error("accepted transfer lost at input stage");

	// a stage 1 item moved forward shows up as the computed result
	a_result_forward: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> (m_axis_tvalid && (m_axis_tdata == $past(result_c))))
		else $error("result register does not hold the computed value");

	// an unfinished result is never dropped by a new load
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |-> !load_s2)
		else $error("pending result overwritten");

endmodule

`default_nettype wire
